@@ rtl/tbtd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbtd_pkg
// Shared types, widths and constants of the touch baseline/threshold block.
// ----------------------------------------------------------------------------
package tbtd_pkg;

	localparam int NUM_CHANNELS = 16;
	localparam int CH_W         = 4;
	localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int SAMPLE_W     = 16;
	localparam int ACC_W        = 24;
	localparam int BASE_W       = 16;
	localparam int CNT_W        = 8;
	localparam int MASK_W       = 16;

	localparam logic [MASK_W-1:0] MASK_RESET  = MASK_W'(16'h00F0);
	localparam logic [CNT_W-1:0]  SCANS_RESET = CNT_W'(50);

	// Touch window: baseline/10 < sample < baseline*6/10.
	localparam int KW = 4;
	localparam logic [KW-1:0] TOUCH_HI_NUM = KW'(6);
	localparam logic [KW-1:0] TOUCH_DEN    = KW'(10);

	// Serial constant multiply: carry and column sum stay below 8.
	localparam int SUM_W     = 3;
	localparam int CMP_W     = SAMPLE_W + KW + 1;
	localparam int CMP_CNT_W = $clog2(CMP_W);
	localparam int ACC_CNT_W = $clog2(ACC_W);

	// Register file.
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 3;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_ENABLE_MASK = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_CAL_SCANS   = 1'b1;

	typedef struct packed {
		logic [CH_W-1:0]     channel;
		logic [SAMPLE_W-1:0] sample;
	} tbtd_in_word_t;

	typedef struct packed {
		logic [CH_W-1:0]   out_channel;
		logic              touched;
		logic              calibrating;
		logic [BASE_W-1:0] baseline_out;
	} tbtd_out_word_t;

	typedef struct packed {
		logic busy;
		logic done;
	} tbtd_unit_sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_CMP_GO,
		ST_CMP_WAIT,
		ST_WRITE
	} tbtd_state_t;

endpackage
`default_nettype wire

@@ rtl/tbtd_sermul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbtd_sermul
// LSB-first bit-serial multiplier of a sample by a small constant.
// ----------------------------------------------------------------------------
module tbtd_sermul (
	input  wire logic                         clk,
	input  wire logic                         load,
	input  wire logic                         step,
	input  wire logic [tbtd_pkg::SAMPLE_W-1:0] x,
	input  wire logic [tbtd_pkg::KW-1:0]       k,
	output logic                              x_bit,
	output logic                              prod_bit
);
	import tbtd_pkg::*;

	logic [SAMPLE_W-1:0] x_sr_q;
	logic [KW-2:0]       dly_q;
	logic [SUM_W-1:0]    carry_q;
	logic [SUM_W-1:0]    sum;
	logic [KW-1:0]       xb;

	// xb[j] is bit (i - j) of x at serial step i.
	always_comb begin
		xb[0] = x_sr_q[0];
		for (int j = 1; j < KW; j++) begin
			xb[j] = dly_q[j-1];
		end
		sum = carry_q;
		for (int j = 0; j < KW; j++) begin
			sum = sum + SUM_W'(k[j] & xb[j]);
		end
	end

	assign x_bit    = xb[0];
	assign prod_bit = sum[0];

	always_ff @(posedge clk) begin
		if (load) begin
			x_sr_q  <= x;
			dly_q   <= '0;
			carry_q <= '0;
		end else if (step) begin
			x_sr_q  <= x_sr_q >> 1;
			dly_q   <= {dly_q[KW-3:0], x_sr_q[0]};
			carry_q <= sum >> 1;
		end
	end

endmodule
`default_nettype wire

@@ rtl/tbtd_sercmp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbtd_sercmp
// Bit-serial touch window test of a sample against a baseline.
// ----------------------------------------------------------------------------
module tbtd_sercmp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [tbtd_pkg::SAMPLE_W-1:0] sample,
	input  wire logic [tbtd_pkg::BASE_W-1:0]   base,
	output tbtd_pkg::tbtd_unit_sts_t           status,
	output logic                               touched
);
	import tbtd_pkg::*;

	// sample < floor(6b/10)  <=>  10*(sample+1) <= 6b
	// sample > floor(b/10)   <=>  b < 10*sample
	logic                 busy_q;
	logic                 done_q;
	logic [CMP_CNT_W-1:0] cnt_q;
	logic [KW-1:0]        cst_sr_q;
	logic                 carry_a_q;
	logic                 le_q;
	logic                 lt_q;
	logic                 c_bit;
	logic                 b6_bit;
	logic                 d_bit;
	logic                 b_unused;
	logic [1:0]           a_sum;

	tbtd_sermul u_mul_smp (
		.clk      (clk),
		.load     (start),
		.step     (busy_q),
		.x        (sample),
		.k        (TOUCH_DEN),
		.x_bit    (b_unused),
		.prod_bit (c_bit)
	);

	tbtd_sermul u_mul_base (
		.clk      (clk),
		.load     (start),
		.step     (busy_q),
		.x        (SAMPLE_W'(base)),
		.k        (TOUCH_HI_NUM),
		.x_bit    (d_bit),
		.prod_bit (b6_bit)
	);

	assign a_sum = {1'b0, c_bit} + {1'b0, cst_sr_q[0]} + {1'b0, carry_a_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CMP_CNT_W'(1);
				if (cnt_q == CMP_CNT_W'(CMP_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cst_sr_q  <= TOUCH_DEN;
			carry_a_q <= 1'b0;
			le_q      <= 1'b1;
			lt_q      <= 1'b0;
		end else if (busy_q) begin
			cst_sr_q  <= cst_sr_q >> 1;
			carry_a_q <= a_sum[1];
			if (a_sum[0] != b6_bit) begin
				le_q <= b6_bit;
			end
			if (d_bit != c_bit) begin
				lt_q <= c_bit;
			end
		end
	end

	assign status  = '{busy: busy_q, done: done_q};
	assign touched = le_q & lt_q & ~(b_unused & 1'b0);

endmodule
`default_nettype wire

@@ rtl/tbtd_serdiv.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbtd_serdiv
// Restoring divider, one quotient bit per cycle, for the baseline average.
// ----------------------------------------------------------------------------
module tbtd_serdiv (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [tbtd_pkg::ACC_W-1:0]  dividend,
	input  wire logic [tbtd_pkg::CNT_W-1:0]  divisor,
	output tbtd_pkg::tbtd_unit_sts_t         status,
	output logic [tbtd_pkg::BASE_W-1:0]      quotient
);
	import tbtd_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [ACC_CNT_W-1:0] cnt_q;
	logic [ACC_W-1:0]     work_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     div_q;
	logic [CNT_W:0]       trial;
	logic [CNT_W:0]       diff;
	logic                 ge;

	// The dividend shifts out at the top while quotient bits enter below.
	assign trial = {rem_q, work_q[ACC_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + ACC_CNT_W'(1);
				if (cnt_q == ACC_CNT_W'(ACC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[ACC_W-2:0], ge};
			rem_q  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	assign status   = '{busy: busy_q, done: done_q};
	assign quotient = work_q[BASE_W-1:0];

endmodule
`default_nettype wire

@@ rtl/touch_baseline_threshold_detect_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// touch_baseline_threshold_detect_core
// Per-channel baseline calibration and touch window detection.
// ----------------------------------------------------------------------------
// Each word on the sample channel carries one raw scan count and its channel
// number, and produces exactly one result word. The first calibration_scans
// samples of an enabled channel are summed into that channel's accumulator;
// the sample that completes the set fixes the baseline at the rounded-down
// average. Later samples are reported as touched when they lie strictly
// between baseline/10 and baseline*6/10. The block works on one word at a
// time and all arithmetic is bit-serial. A word for a disabled channel goes
// straight to the result register, an evaluated sample first passes the
// 21-bit serial window comparator, a calibration sample the 24-bit serial
// accumulate, and the sample that completes calibration the accumulate and
// then the 24-step serial divider. Each word then waits to be written while
// the result register still holds a stalled result. A new word is taken
// while a finished result still waits downstream. The enable mask lies at
// byte address 0 and the scan count at address 4. The user must write both
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module touch_baseline_threshold_detect_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Sample channel.
	input  wire logic                          sample_valid,
	output logic                               sample_stall,
	input  wire tbtd_pkg::tbtd_in_word_t       sample_word,
	// Result channel.
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output tbtd_pkg::tbtd_out_word_t           result_word,
	// Register port.
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tbtd_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [tbtd_pkg::DATA_W-1:0]   pwdata,
	output logic [tbtd_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);
	import tbtd_pkg::*;

	// Configuration registers.
	logic [MASK_W-1:0]    mask_q;
	logic [CNT_W-1:0]     scans_q;
	logic [REG_IDX_W-1:0] reg_idx;

	// Per-channel state.
	logic [ACC_W-1:0]  acc_mem_q  [NUM_CHANNELS];
	logic [BASE_W-1:0] base_mem_q [NUM_CHANNELS];
	logic [CNT_W-1:0]  cnt_mem_q  [NUM_CHANNELS];

	// Control.
	tbtd_state_t          state_q;
	tbtd_state_t          state_d;
	logic [ACC_CNT_W-1:0] bit_q;
	logic                 accept;
	logic                 out_free;
	logic                 commit;
	logic                 add_step;
	logic                 div_start;
	logic                 cmp_start;

	// Decision on the incoming word.
	logic [CH_IDX_W-1:0] in_idx;
	logic                in_range;
	logic                in_enabled;
	logic                in_calib;
	logic                in_eval;

	// Working registers of the current word.
	logic [CH_W-1:0]     ch_q;
	logic [SAMPLE_W-1:0] smp_q;
	logic [ACC_W-1:0]    acc_sr_q;
	logic [SAMPLE_W-1:0] add_sr_q;
	logic                carry_q;
	logic [BASE_W-1:0]   base_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    cnt_inc;
	logic                calib_q;
	logic                touched_q;
	logic [1:0]          add_sum;
	logic                last_bit;
	tbtd_out_word_t      result_q;
	logic                result_valid_q;

	// Arithmetic units.
	tbtd_unit_sts_t    div_sts;
	tbtd_unit_sts_t    cmp_sts;
	logic [BASE_W-1:0] div_quot;
	logic              cmp_touched;

	// ------------------------------------------------------------------
	// Register port. Only the word address bit selects a register, so
	// every write lands in one of the two.
	// ------------------------------------------------------------------
	assign reg_idx = paddr[ADDR_W-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= MASK_RESET;
			scans_q <= SCANS_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_ENABLE_MASK: mask_q  <= pwdata[MASK_W-1:0];
				REG_CAL_SCANS:   scans_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ENABLE_MASK: prdata = DATA_W'(mask_q);
			REG_CAL_SCANS:   prdata = DATA_W'(scans_q);
			default:         prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Classification of the incoming word. Channels beyond the channel
	// count behave as disabled and report a zero baseline.
	// ------------------------------------------------------------------
	assign in_idx     = sample_word.channel[CH_IDX_W-1:0];
	assign in_range   = ((CH_W+1)'(sample_word.channel) < (CH_W+1)'(NUM_CHANNELS));
	assign in_enabled = in_range && mask_q[sample_word.channel];
	assign in_calib   = in_enabled && (cnt_mem_q[in_idx] < scans_q);
	assign in_eval    = in_enabled && !in_calib;

	assign accept   = sample_valid && !sample_stall;
	assign out_free = !result_valid_q || !result_stall;
	assign cnt_inc  = cnt_q + CNT_W'(1);
	assign last_bit = (bit_q == ACC_CNT_W'(ACC_W - 1));

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_calib) begin
						state_d = ST_ADD;
					end else if (in_eval) begin
						state_d = ST_CMP_GO;
					end else begin
						state_d = ST_WRITE;
					end
				end
			end
			ST_ADD: begin
				if (last_bit) begin
					state_d = (cnt_inc == scans_q) ? ST_DIV_GO : ST_WRITE;
				end
			end
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_sts.done) begin
					state_d = ST_WRITE;
				end
			end
			ST_CMP_GO:   state_d = ST_CMP_WAIT;
			ST_CMP_WAIT: begin
				if (cmp_sts.done) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		sample_stall = 1'b1;
		add_step     = 1'b0;
		div_start    = 1'b0;
		cmp_start    = 1'b0;
		commit       = 1'b0;
		case (state_q)
			ST_IDLE:   sample_stall = 1'b0;
			ST_ADD:    add_step     = 1'b1;
			ST_DIV_GO: div_start    = 1'b1;
			ST_CMP_GO: cmp_start    = 1'b1;
			ST_WRITE:  commit       = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (accept) begin
			bit_q <= '0;
		end else if (add_step) begin
			bit_q <= bit_q + ACC_CNT_W'(1);
		end
	end

	// ------------------------------------------------------------------
	// Datapath. The accumulate runs LSB first: the accumulator rotates
	// through its shift register while the sample bits are added in.
	// ------------------------------------------------------------------
	assign add_sum = {1'b0, acc_sr_q[0]} + {1'b0, add_sr_q[0]} + {1'b0, carry_q};

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q      <= sample_word.channel;
			smp_q     <= sample_word.sample;
			add_sr_q  <= sample_word.sample;
			carry_q   <= 1'b0;
			acc_sr_q  <= in_range ? acc_mem_q[in_idx] : '0;
			base_q    <= in_range ? base_mem_q[in_idx] : '0;
			cnt_q     <= in_range ? cnt_mem_q[in_idx] : '0;
			calib_q   <= in_calib;
			touched_q <= 1'b0;
		end else if (add_step) begin
			acc_sr_q <= {add_sum[0], acc_sr_q[ACC_W-1:1]};
			add_sr_q <= add_sr_q >> 1;
			carry_q  <= add_sum[1];
		end else if (state_q == ST_DIV_WAIT && div_sts.done) begin
			base_q <= div_quot;
		end else if (state_q == ST_CMP_WAIT && cmp_sts.done) begin
			touched_q <= cmp_touched;
		end
	end

	// Channel state is zero after reset and updated when a calibration
	// word completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				acc_mem_q[c]  <= '0;
				base_mem_q[c] <= '0;
				cnt_mem_q[c]  <= '0;
			end
		end else if (commit && calib_q) begin
			acc_mem_q[ch_q[CH_IDX_W-1:0]]  <= acc_sr_q;
			base_mem_q[ch_q[CH_IDX_W-1:0]] <= base_q;
			cnt_mem_q[ch_q[CH_IDX_W-1:0]]  <= cnt_inc;
		end
	end

	tbtd_serdiv u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_sr_q),
		.divisor  (scans_q),
		.status   (div_sts),
		.quotient (div_quot)
	);

	tbtd_sercmp u_cmp (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmp_start),
		.sample  (smp_q),
		.base    (base_q),
		.status  (cmp_sts),
		.touched (cmp_touched)
	);

	// ------------------------------------------------------------------
	// Result register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (commit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			result_q <= '{out_channel:  ch_q,
			              touched:      touched_q,
			              calibrating:  calib_q,
			              baseline_out: base_q};
		end
	end

	assign result_valid = result_valid_q;
	assign result_word  = result_q;

endmodule
`default_nettype wire

@@ rtl/tbtd_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbtd_checker
// Port-level checks of the touch baseline/threshold block.
// ----------------------------------------------------------------------------
module tbtd_checker (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     sample_valid,
	input wire logic                     sample_stall,
	input wire tbtd_pkg::tbtd_out_word_t result_word,
	input wire logic                     result_valid,
	input wire logic                     result_stall
);
	import tbtd_pkg::*;

	// A stalled result word holds until it is taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_word))
		else $error("result word changed while stalled");

	// The block takes one word at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
		else $error("second word accepted while busy");

	// A calibration sample is never evaluated as a touch.
	a_touch_not_calib: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result_word.touched && result_word.calibrating))
		else $error("touch reported on a calibration sample");

	// A touch needs a window, which a zero baseline does not have.
	a_touch_needs_base: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.touched |-> result_word.baseline_out != '0)
		else $error("touch reported with a zero baseline");

endmodule

bind touch_baseline_threshold_detect_core tbtd_checker u_checker (.*);
`default_nettype wire
